// ----- design/pfes_pkg.sv -----
// Shared types and constants for the PowerPC function extent scanner.
// Holds the decoded item, the configuration bundle, register indexes and end reasons.
// No dependencies.
`default_nettype none

package pfes_pkg;

  localparam int ADDR_W = 32;
  localparam int WORD_W = 32;

  // Exact words and masked opcode patterns.
  localparam logic [WORD_W-1:0] XO_MASK      = 32'hFC0007FE;
  localparam logic [WORD_W-1:0] MFSPR_PAT    = 32'h7C0002A6;
  localparam logic [WORD_W-1:0] BLR_WORD     = 32'h4E800020;
  localparam logic [WORD_W-1:0] BCTR_WORD    = 32'h4E800420;
  localparam logic [WORD_W-1:0] BCLR_PAT     = 32'h4C000020;
  localparam logic [WORD_W-1:0] BCCTR_PAT    = 32'h4C000420;
  localparam logic [5:0]        PRIM_B       = 6'd18;
  localparam logic [5:0]        PRIM_BC      = 6'd16;
  // LR is SPR 8; the SPR field is stored with its two halves swapped.
  localparam logic [4:0]        SPR_LR_HI    = 5'd8;
  localparam logic [4:0]        SPR_LR_LO    = 5'd0;

  localparam logic [ADDR_W-1:0] EPI_LO_RESET = 32'h0000_0001;
  localparam logic [ADDR_W-1:0] WORD_BYTES   = 32'd4;

  typedef enum logic [1:0] {
    CFG_START  = 2'd0,
    CFG_BOUND  = 2'd1,
    CFG_EPI_LO = 2'd2,
    CFG_EPI_HI = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    RSN_ZERO    = 3'd0,
    RSN_RETURN  = 3'd1,
    RSN_BACK    = 3'd2,
    RSN_TAIL    = 3'd3,
    RSN_EPILOG  = 3'd4,
    RSN_THUNK   = 3'd5,
    RSN_OVERRUN = 3'd6
  } reason_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start_addr;
    logic [ADDR_W-1:0] bound_addr;
    logic [ADDR_W-1:0] epi_lo;
    logic [ADDR_W-1:0] epi_hi;
  } cfg_t;

  // One instruction word after classification.
  typedef struct packed {
    logic              restart;
    logic              is_zero;
    logic              is_mfspr_lr;
    logic              is_ret;
    logic              is_b;
    logic              is_bc;
    logic              is_lrctr;
    logic              absolute;
    logic              link;
    logic [ADDR_W-1:0] disp;
  } item_t;

endpackage

`default_nettype wire

// ----- design/pfes_front.sv -----
// Front end of the scanner: accepts instruction words, classifies them and
// queues the decoded items for the back end. Depends on pfes_pkg.
`default_nettype none

module pfes_front import pfes_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [WORD_W-1:0] in_instruction_word,
  input  wire logic              in_restart,
  output logic                   q_valid,
  output item_t                  q_item,
  input  wire logic              q_pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             dec;
  item_t             mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              push;
  logic [WORD_W-1:0] w;

  assign w = in_instruction_word;

  always_comb begin
    dec             = '0;
    dec.restart     = in_restart;
    dec.is_zero     = (w == '0);
    dec.is_mfspr_lr = ((w & XO_MASK) == MFSPR_PAT) && (w[20:16] == SPR_LR_HI)
                      && (w[15:11] == SPR_LR_LO);
    dec.is_ret      = (w == BLR_WORD) || (w == BCTR_WORD);
    dec.is_b        = !dec.is_ret && (w[31:26] == PRIM_B);
    dec.is_bc       = !dec.is_ret && (w[31:26] == PRIM_BC);
    dec.is_lrctr    = !dec.is_ret && (((w & XO_MASK) == BCLR_PAT) ||
                                      ((w & XO_MASK) == BCCTR_PAT));
    dec.absolute    = w[1];
    dec.link        = w[0];
    if (w[31:26] == PRIM_B) begin
      dec.disp = {{6{w[25]}}, w[25:2], 2'b00};
    end else begin
      dec.disp = {{16{w[15]}}, w[15:2], 2'b00};
    end
  end

  assign in_stall = (count_r == CNT_W'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= dec;
    end
  end

endmodule

`default_nettype wire

// ----- design/pfes_back.sv -----
// Back end of the scanner, depends on pfes_pkg: keeps the scan state and drives
// the result register; retires one decoded item per cycle unless a held result stalls.
`default_nettype none

module pfes_back import pfes_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire logic              q_valid,
  input  wire item_t             q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ADDR_W-1:0]      out_function_end,
  output logic [2:0]             out_end_reason,
  output logic                   out_ran_short
);

  logic              active_r, active_nxt;
  logic [ADDR_W-1:0] scan_addr_r, scan_addr_nxt;
  logic [ADDR_W-1:0] far_r, far_nxt;
  logic              open_r, open_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              hp_r, hp_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_end_r;
  reason_t           out_reason_r;
  logic              out_short_r;

  logic              go;
  logic              out_load;
  logic [ADDR_W-1:0] base_addr, base_far;
  logic              base_open, base_hp;
  logic [1:0]        base_cnt;
  logic [ADDR_W-1:0] addr_m4, addr_p4, addr_p8;
  logic [ADDR_W-1:0] tgt;
  logic              tgt_epi, cond, hp_new, plain_b, blk_end;
  logic [1:0]        cnt_new;
  logic [ADDR_W-1:0] far_new;
  logic              res_hit;
  reason_t           res_reason;
  logic [ADDR_W-1:0] res_end, res_plus4;
  logic              res_short;

  // The result register frees up in the same cycle that its transfer completes.
  assign q_pop    = q_valid && (!out_valid_r || !out_stall);
  assign go       = q_pop && (q_item.restart || active_r);
  assign out_load = go && res_hit;

  always_comb begin
    base_addr = q_item.restart ? cfg.start_addr : scan_addr_r;
    base_far  = q_item.restart ? cfg.start_addr : far_r;
    base_open = q_item.restart ? 1'b0 : open_r;
    base_cnt  = q_item.restart ? 2'd0 : cnt_r;
    base_hp   = q_item.restart ? 1'b0 : hp_r;

    addr_m4 = base_addr - WORD_BYTES;
    addr_p4 = base_addr + WORD_BYTES;
    addr_p8 = base_addr + (WORD_BYTES << 1);

    tgt     = q_item.absolute ? q_item.disp : q_item.disp + base_addr;
    tgt_epi = (cfg.epi_lo <= cfg.epi_hi) && (tgt >= cfg.epi_lo) && (tgt <= cfg.epi_hi);
    cond    = (base_far <= base_addr);
    hp_new  = base_hp || ((base_addr == cfg.start_addr) && q_item.is_mfspr_lr);
    cnt_new = (base_open || base_cnt == 2'd2) ? base_cnt : base_cnt + 2'd1;
    plain_b = q_item.is_b && !q_item.link;
    blk_end = q_item.is_ret || q_item.is_b || q_item.is_bc || q_item.is_lrctr;

    far_new = base_far;
    if ((q_item.is_b || q_item.is_bc) && !q_item.link && !tgt_epi && (tgt > base_far)) begin
      far_new = tgt;
    end

    res_hit    = 1'b1;
    res_reason = RSN_ZERO;
    res_end    = base_addr;
    res_plus4  = addr_p4;
    if (q_item.is_zero) begin
      res_end   = addr_m4;
      res_plus4 = base_addr;
    end else if (q_item.is_ret && cond) begin
      res_reason = RSN_RETURN;
    end else if (plain_b && (tgt >= cfg.start_addr) && (tgt < base_addr) && cond) begin
      res_reason = RSN_BACK;
    end else if (plain_b && (tgt < cfg.start_addr) && cond) begin
      res_reason = RSN_TAIL;
    end else if (plain_b && cond && tgt_epi) begin
      res_reason = RSN_EPILOG;
    end else if (plain_b && !hp_new && (cnt_new == 2'd1)) begin
      res_reason = RSN_THUNK;
    end else if ((cfg.bound_addr != '0) && (addr_p4 > cfg.bound_addr)) begin
      res_reason = RSN_OVERRUN;
      res_end    = addr_p4;
      res_plus4  = addr_p8;
    end else begin
      res_hit = 1'b0;
    end
    res_short = (cfg.bound_addr != '0) && (res_plus4 < cfg.bound_addr);
  end

  always_comb begin
    active_nxt    = active_r;
    scan_addr_nxt = scan_addr_r;
    far_nxt       = far_r;
    open_nxt      = open_r;
    cnt_nxt       = cnt_r;
    hp_nxt        = hp_r;
    if (go) begin
      active_nxt    = !res_hit;
      scan_addr_nxt = addr_p4;
      far_nxt       = far_new;
      open_nxt      = !blk_end;
      cnt_nxt       = cnt_new;
      hp_nxt        = hp_new;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      scan_addr_r <= '0;
      far_r       <= '0;
      open_r      <= 1'b0;
      cnt_r       <= 2'd0;
      hp_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      scan_addr_r <= scan_addr_nxt;
      far_r       <= far_nxt;
      open_r      <= open_nxt;
      cnt_r       <= cnt_nxt;
      hp_r        <= hp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_end_r    <= res_end;
      out_reason_r <= res_reason;
      out_short_r  <= res_short;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_function_end = out_end_r;
  assign out_end_reason   = out_reason_r;
  assign out_ran_short    = out_short_r;

  a_idle_word_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !q_item.restart && !active_r) |-> !out_load)
    else $error("word taken while idle produced a result");

  a_result_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (!active_r && out_valid_r))
    else $error("scan still active after its result");

  a_overrun_past_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res_reason == RSN_OVERRUN) |-> (res_end > cfg.bound_addr))
    else $error("overrun reported inside the bound");

  a_block_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("block count passed saturation");

endmodule

`default_nettype wire

// ----- design/ppc_function_extent_scanner_core.sv -----
// A word that ends the function shows its result after the queue and the result register.
// Throughput: one word per cycle unless a held result is stalled at the output, set by the
// scan state update in the back end.
// Reset (synchronous, rst_n low): queue empty, no scan active, result register empty,
// registers back to start 0, bound 0, epilog range empty (low 1, high 0).
`default_nettype none

module ppc_function_extent_scanner_core import pfes_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [ADDR_W-1:0] cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [WORD_W-1:0] in_instruction_word,
  input  wire logic              in_restart,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ADDR_W-1:0]      out_function_end,
  output logic [2:0]             out_end_reason,
  output logic                   out_ran_short
);

  cfg_t  cfg_r, cfg_nxt;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_START:  cfg_nxt.start_addr = cfg_wdata;
        CFG_BOUND:  cfg_nxt.bound_addr = cfg_wdata;
        CFG_EPI_LO: cfg_nxt.epi_lo     = cfg_wdata;
        CFG_EPI_HI: cfg_nxt.epi_hi     = cfg_wdata;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_addr <= '0;
      cfg_r.bound_addr <= '0;
      cfg_r.epi_lo     <= EPI_LO_RESET;
      cfg_r.epi_hi     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pfes_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_instruction_word (in_instruction_word),
    .in_restart          (in_restart),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop)
  );

  pfes_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_function_end (out_function_end),
    .out_end_reason   (out_end_reason),
    .out_ran_short    (out_ran_short)
  );

endmodule

`default_nettype wire

// ----- verif/tb_ppc_function_extent_scanner_core.sv -----
// Self-checking testbench for ppc_function_extent_scanner_core.
// Streams instruction words and predicts each end address, reason and ran-short flag.
// Depends on pfes_pkg and the scanner core only.
`default_nettype none

module tb_ppc_function_extent_scanner_core import pfes_pkg::*; ();

  localparam logic [WORD_W-1:0] NOP_WORD   = 32'h6000_0000;
  localparam logic [WORD_W-1:0] ADDI_WORD  = 32'h3860_0000;
  localparam logic [WORD_W-1:0] MFLR_FIELD = 32'h0008_0000;
  localparam logic [9:0]        SPR_LR     = 10'd8;
  localparam int                WORDS_PER_PHASE = 216;

  typedef struct packed {
    logic [ADDR_W-1:0] fend;
    reason_t           why;
    logic              ran_short;
  } extent_t;

  // Tracks the scan as the core should see it and holds the ends still owed.
  class extent_scoreboard;
    cfg_t        regs;
    logic [31:0] scan_addr;
    logic [31:0] far_target;
    logic        blk_open;
    logic [1:0]  blk_count;
    logic        prolog_seen;
    logic        scanning;
    extent_t     ends_q[$];
    int          errors;

    function new();
      regs.start_addr = '0;
      regs.bound_addr = '0;
      regs.epi_lo     = EPI_LO_RESET;
      regs.epi_hi     = '0;
      scan_addr   = '0;
      far_target  = '0;
      blk_open    = 1'b0;
      blk_count   = '0;
      prolog_seen = 1'b0;
      scanning    = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [31:0] v);
      case (idx)
        CFG_START:  regs.start_addr = v;
        CFG_BOUND:  regs.bound_addr = v;
        CFG_EPI_LO: regs.epi_lo = v;
        CFG_EPI_HI: regs.epi_hi = v;
        default: ;
      endcase
    endfunction

    function bit in_epi(logic [31:0] t);
      return regs.epi_lo <= regs.epi_hi && t >= regs.epi_lo && t <= regs.epi_hi;
    endfunction

    function void close_scan(logic [31:0] e, reason_t r);
      extent_t x;
      scanning = 1'b0;
      x.fend = e;
      x.why = r;
      x.ran_short = regs.bound_addr != '0 && (e + WORD_BYTES) < regs.bound_addr;
      ends_q.insert(ends_q.size(), x);
    endfunction

    // Returns 1 when the word takes part in a scan, 0 when the core ignores it.
    function bit note_word(logic [31:0] w, logic rs);
      logic [31:0] addr, li, bd, tgt;
      logic        fwd_ok;
      if (rs) begin
        scan_addr   = regs.start_addr;
        far_target  = regs.start_addr;
        blk_open    = 1'b0;
        blk_count   = '0;
        prolog_seen = 1'b0;
        scanning    = 1'b1;
      end else if (!scanning) begin
        return 1'b0;
      end
      addr = scan_addr;
      if (w == '0) begin
        close_scan(addr - WORD_BYTES, RSN_ZERO);
        return 1'b1;
      end
      // The SPR field is stored with its two five-bit halves swapped.
      if (addr == regs.start_addr && (w & XO_MASK) == MFSPR_PAT &&
          {w[15:11], w[20:16]} == SPR_LR)
        prolog_seen = 1'b1;
      if (!blk_open) begin
        blk_open = 1'b1;
        if (blk_count < 2'd2) blk_count++;
      end
      fwd_ok = far_target <= addr;
      if (w == BLR_WORD || w == BCTR_WORD) begin
        blk_open = 1'b0;
        if (fwd_ok) begin
          close_scan(addr, RSN_RETURN);
          return 1'b1;
        end
      end else if (w[31:26] == PRIM_B) begin
        li = {{6{w[25]}}, w[25:2], 2'b00};
        tgt = w[1] ? li : li + addr;
        blk_open = 1'b0;
        if (!w[0]) begin
          if (tgt >= regs.start_addr && tgt < addr && fwd_ok) begin
            close_scan(addr, RSN_BACK);
            return 1'b1;
          end
          if (tgt < regs.start_addr && fwd_ok) begin
            close_scan(addr, RSN_TAIL);
            return 1'b1;
          end
          if (fwd_ok && in_epi(tgt)) begin
            close_scan(addr, RSN_EPILOG);
            return 1'b1;
          end
          if (!prolog_seen && blk_count == 2'd1) begin
            close_scan(addr, RSN_THUNK);
            return 1'b1;
          end
          if (!in_epi(tgt) && tgt > far_target) far_target = tgt;
        end
      end else if (w[31:26] == PRIM_BC) begin
        bd = {{16{w[15]}}, w[15:2], 2'b00};
        tgt = w[1] ? bd : bd + addr;
        blk_open = 1'b0;
        if (!w[0] && !in_epi(tgt) && tgt > far_target) far_target = tgt;
      end else if ((w & XO_MASK) == BCLR_PAT || (w & XO_MASK) == BCCTR_PAT) begin
        blk_open = 1'b0;
      end
      addr = addr + WORD_BYTES;
      scan_addr = addr;
      if (regs.bound_addr != '0 && addr > regs.bound_addr) close_scan(addr, RSN_OVERRUN);
      return 1'b1;
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_result(logic [31:0] fe, logic [2:0] rsn, logic rsh);
      extent_t x;
      if (ends_q.size() == 0) begin
        report($sformatf("unexpected result end=%h reason=%0d short=%0b", fe, rsn, rsh));
        return;
      end
      x = ends_q.pop_front();
      if (fe !== x.fend)
        report($sformatf("function_end %h, expected %h", fe, x.fend));
      if (rsn !== x.why)
        report($sformatf("end_reason %0d, expected %s", rsn, x.why.name()));
      if (rsh !== x.ran_short)
        report($sformatf("ran_short %0b, expected %0b at end %h", rsh, x.ran_short, x.fend));
    endtask

    function int pending();
      return ends_q.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [1:0]        cfg_index = CFG_START;
  logic [ADDR_W-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [WORD_W-1:0] in_instruction_word = '0;
  logic              in_restart = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ADDR_W-1:0] out_function_end;
  logic [2:0]        out_end_reason;
  logic              out_ran_short;

  extent_scoreboard sb;
  int send_idle = 0;
  int stall_pct = 0;
  int words_used = 0;

  ppc_function_extent_scanner_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_instruction_word (in_instruction_word),
    .in_restart          (in_restart),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_function_end    (out_function_end),
    .out_end_reason      (out_end_reason),
    .out_ran_short       (out_ran_short)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= $urandom_range(99) < stall_pct;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_function_end, out_end_reason, out_ran_short);
  end

  initial begin
    #5_000_000;
    $display("timeout: scanner stopped making progress");
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [31:0] b_word(logic [31:0] disp, logic aa, logic lk);
    return {PRIM_B, disp[25:2], aa, lk};
  endfunction

  function automatic logic [31:0] bc_word(logic [31:0] disp, logic aa, logic lk);
    logic [31:0] bobi;
    bobi = $urandom;
    return {PRIM_BC, bobi[9:0], disp[15:2], aa, lk};
  endfunction

  function automatic bit fits26(logic [31:0] d);
    return d[31:25] == 7'h00 || d[31:25] == 7'h7F;
  endfunction

  // Picks one word for the given address, weighted toward the branch forms that end scans.
  function automatic logic [31:0] body_word(logic [31:0] addr);
    int unsigned pick;
    logic [31:0] w, d, tgt, span, off;
    logic        lk;
    pick = $urandom_range(99);
    w = $urandom;
    lk = $urandom_range(7) == 0;
    if (pick < 40) begin
      if (w == '0) w = NOP_WORD;
    end else if (pick < 50) begin
      w = b_word(32'd4 * $urandom_range(1, 64), 1'b0, $urandom_range(3) == 0);
    end else if (pick < 58) begin
      d = -(32'd4 * $urandom_range(0, 24));
      w = b_word(d, 1'b0, lk);
    end else if (pick < 63) begin
      if (sb.regs.epi_lo <= sb.regs.epi_hi) begin
        span = sb.regs.epi_hi - sb.regs.epi_lo;
        if (span > 32'h400) off = $urandom_range(32'h400);
        else off = $urandom_range(span);
        tgt = sb.regs.epi_lo + (off & ~32'd3);
        d = tgt - addr;
        if (fits26(d)) w = b_word(d, 1'b0, lk);
        else if (fits26(tgt)) w = b_word(tgt, 1'b1, lk);
        else w = b_word(d, 1'b0, lk);
      end else begin
        w = b_word(w, 1'b1, 1'b0);
      end
    end else if (pick < 68) begin
      w = {PRIM_B, w[25:0]};
    end else if (pick < 78) begin
      if ($urandom_range(1)) d = 32'd4 * $urandom_range(0, 32);
      else d = -(32'd4 * $urandom_range(1, 32));
      w = bc_word(d, $urandom_range(9) == 0, $urandom_range(3) == 0);
    end else if (pick < 86) begin
      w = $urandom_range(1) ? BLR_WORD : BCTR_WORD;
    end else if (pick < 92) begin
      w = ($urandom_range(1) ? BCLR_PAT : BCCTR_PAT) | (w & 32'h03FF_F801);
    end else if (pick < 95) begin
      w = '0;
    end else if (pick < 97) begin
      w = MFSPR_PAT | (w & 32'h03FF_F801);
    end
    return w;
  endfunction

  task automatic put_reg(cfg_idx_t idx, logic [31:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic configure(logic [31:0] s, logic [31:0] b, logic [31:0] lo, logic [31:0] hi);
    put_reg(CFG_START, s);
    put_reg(CFG_BOUND, b);
    put_reg(CFG_EPI_LO, lo);
    put_reg(CFG_EPI_HI, hi);
    cfg_wr_en <= 1'b0;
  endtask

  // Offers one word and returns once it has been transferred.
  task automatic send_word(logic [31:0] w, logic rs);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_instruction_word <= w;
    in_restart <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (sb.note_word(w, rs)) words_used++;
  endtask

  task automatic run_function(int max_len);
    logic [31:0] first;
    int n;
    if ($urandom_range(4) == 0) first = MFSPR_PAT | MFLR_FIELD | ($urandom & 32'h03E0_0001);
    else first = body_word(sb.regs.start_addr);
    send_word(first, 1'b1);
    n = 1;
    while (sb.scanning && n < max_len) begin
      if ($urandom_range(49) == 0) send_word(body_word(sb.regs.start_addr), 1'b1);
      else send_word(body_word(sb.scan_addr), 1'b0);
      n++;
    end
  endtask

  // Waits for every owed result, then lets words that end nothing leave the core.
  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sb.pending() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [31:0] s, b, lo, hi;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Start 0x1000 with the bound two words in, epilog routines at 0x8000.
    configure(32'h1000, 32'h1008, 32'h8000, 32'h80FF);
    send_word(32'h0, 1'b1);
    send_word(32'h1234_5678, 1'b0);
    send_word(BLR_WORD, 1'b1);
    send_word(BCTR_WORD, 1'b1);
    send_word(MFSPR_PAT | MFLR_FIELD, 1'b1);
    send_word(ADDI_WORD, 1'b0);
    send_word(b_word(-32'd8, 1'b0, 1'b0), 1'b0);
    send_word(NOP_WORD, 1'b1);
    send_word(b_word(-32'h10, 1'b0, 1'b0), 1'b0);
    send_word(b_word(32'h8000, 1'b1, 1'b0), 1'b1);
    send_word(b_word(32'h100, 1'b0, 1'b0), 1'b1);
    send_word(b_word(32'h40, 1'b0, 1'b1), 1'b1);
    send_word(bc_word(32'd16, 1'b0, 1'b0), 1'b0);
    send_word(BLR_WORD, 1'b0);
    send_word(BCLR_PAT | 32'h0182_0000, 1'b1);
    send_word(BCTR_WORD | 32'h1, 1'b0);
    send_word(bc_word(32'h20, 1'b0, 1'b1), 1'b0);
    send_word(NOP_WORD, 1'b1);
    send_word(BLR_WORD, 1'b1);
    send_word(MFSPR_PAT | MFLR_FIELD, 1'b1);
    send_word(b_word(32'h20, 1'b0, 1'b0), 1'b0);
    send_word(NOP_WORD, 1'b0);
    settle();

    for (int p = 0; p < 8; p++) begin
      s = $urandom & 32'hFFFF_FFFC;
      case (p)
        0: begin
          b = '0; lo = 32'h1; hi = '0;
        end
        1: begin
          s = '0; b = 32'hFFFF_FFFF; lo = '0; hi = 32'hFFFF_FFFF;
        end
        2: begin
          s = 32'hFFFF_FF00; b = '0; lo = 32'hFFFF_FFFF; hi = '0;
        end
        3: begin
          // Random start, which may be off word alignment, with a bound 2 to 40 words out.
          s = $urandom;
          b = s + 32'd4 * $urandom_range(2, 40);
          lo = s + 32'h100; hi = s + 32'h1FF;
        end
        default: begin
          b = $urandom_range(1) ? s + 32'd4 * $urandom_range(1, 64) : '0;
          case ($urandom_range(2))
            0: lo = s + 32'h80;
            1: lo = s - 32'h400;
            default: lo = $urandom;
          endcase
          hi = (lo[0] && p == 7) ? lo - 32'd1 - $urandom_range(255) : lo + 32'hFF;
        end
      endcase
      configure(s, b, lo, hi);
      case (p % 4)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 70; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 70; end
        default: begin send_idle = 37; stall_pct = 37; end
      endcase
      words_used = 0;
      while (words_used < WORDS_PER_PHASE) begin
        if ($urandom_range(9) == 0) send_word($urandom, 1'b0);
        else run_function($urandom_range(1, 40));
      end
      settle();
    end

    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
design/pfes_pkg.sv
design/pfes_front.sv
design/pfes_back.sv
design/ppc_function_extent_scanner_core.sv
verif/tb_ppc_function_extent_scanner_core.sv
